>>> hdl/dwarf_rnglists_address_rebase_macros.svh
`ifndef DWARF_RNGLISTS_ADDRESS_REBASE_MACROS_SVH
`define DWARF_RNGLISTS_ADDRESS_REBASE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define DRAR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define DRAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/drar_pkg.sv
package drar_pkg;

    typedef enum logic [2:0] {
        PH_LEN          = 3'd0,
        PH_HDR          = 3'd1,
        PH_OFFS         = 3'd2,
        PH_KIND         = 3'd3,
        PH_OPER         = 3'd4,
        PH_PASS_UNIT    = 3'd5,
        PH_PASS_SECTION = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_NORMAL       = 2'd0,
        ST_UNIT_PASS    = 2'd1,
        ST_SECTION_PASS = 2'd2
    } status_t;

    localparam logic [2:0] KIND_END_OF_LIST   = 3'd0;
    localparam logic [2:0] KIND_BASE_ADDRESSX = 3'd1;
    localparam logic [2:0] KIND_BASE_ADDRESS  = 3'd5;
    localparam logic [2:0] KIND_START_END     = 3'd6;
    localparam logic [2:0] KIND_START_LENGTH  = 3'd7;
    localparam logic [7:0] KIND_MAX           = 8'h07;

    localparam logic [63:0] LEN_ESCAPE = 64'h0000_0000_ffff_ffff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sect_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       address_patched;
        status_t    parse_status;
        logic       last_out;
    } patch_beat_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] idx;
    } enter_t;

    function automatic logic [1:0] operand_count(input logic [2:0] kind);
        logic [1:0] cnt;
        if (kind == KIND_END_OF_LIST)
        begin
            cnt = 2'd0;
        end
        else if (kind == KIND_BASE_ADDRESSX || kind == KIND_BASE_ADDRESS)
        begin
            cnt = 2'd1;
        end
        else
        begin
            cnt = 2'd2;
        end
        return cnt;
    endfunction

    function automatic logic operand_is_address(input logic [2:0] kind,
                                                input logic [1:0] idx);
        return (kind == KIND_BASE_ADDRESS) || (kind == KIND_START_END)
            || ((kind == KIND_START_LENGTH) && (idx == 2'd0));
    endfunction

    // Steps past address operands that occupy no bytes.
    function automatic enter_t enter_operand(input logic [2:0] kind,
                                             input logic [1:0] idx,
                                             input logic [7:0] addr_bytes);
        enter_t     r;
        logic [1:0] i;
        logic       done;
        i = idx;
        done = 1'b0;
        r.phase = PH_OPER;
        for (int k = 0; k < 3; k++)
        begin
            if (!done)
            begin
                if (i >= operand_count(kind))
                begin
                    r.phase = PH_KIND;
                    done = 1'b1;
                end
                else if (operand_is_address(kind, i) && (addr_bytes == 8'd0))
                begin
                    i = i + 2'd1;
                end
                else
                begin
                    r.phase = PH_OPER;
                    done = 1'b1;
                end
            end
        end
        r.idx = i;
        return r;
    endfunction

endpackage

>>> hdl/drar_parser.sv
`include "dwarf_rnglists_address_rebase_macros.svh"

module drar_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  drar_pkg::sect_beat_t  beat,
    input  logic [63:0]           bias,
    output drar_pkg::patch_beat_t result
);

    drar_pkg::phase_t phase_reg, phase_next;
    logic [63:0] unit_remaining_reg, unit_remaining_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic        long_format_reg, long_format_next;
    logic [7:0]  address_size_reg, address_size_next;
    logic [35:0] offset_skip_reg, offset_skip_next;
    logic [2:0]  entry_kind_reg, entry_kind_next;
    logic [1:0]  operand_index_reg, operand_index_next;
    logic [7:0]  address_byte_index_reg, address_byte_index_next;
    logic        add_carry_reg, add_carry_next;

    logic             in_unit;
    logic             len_done;
    logic             clear;
    logic [63:0]      len_acc;
    logic [35:0]      offs_acc;
    logic [35:0]      offs_dec;
    logic [63:0]      rem_dec;
    logic [7:0]       bias_byte;
    logic [8:0]       sum;
    logic [8:0]       abi_inc;
    logic [63:0]      bias_shift;
    drar_pkg::enter_t ent;

    always_comb
    begin
        phase_next              = phase_reg;
        unit_remaining_next     = unit_remaining_reg;
        header_index_next       = header_index_reg;
        long_format_next        = long_format_reg;
        address_size_next       = address_size_reg;
        offset_skip_next        = offset_skip_reg;
        entry_kind_next         = entry_kind_reg;
        operand_index_next      = operand_index_reg;
        address_byte_index_next = address_byte_index_reg;
        add_carry_next          = add_carry_reg;

        result.out_byte        = beat.data_byte;
        result.address_patched = 1'b0;
        result.parse_status    = drar_pkg::ST_NORMAL;
        result.last_out        = beat.last_byte;

        in_unit    = 1'b1;
        len_done   = 1'b0;
        clear      = 1'b0;
        len_acc    = unit_remaining_reg;
        offs_acc   = offset_skip_reg;
        offs_dec   = offset_skip_reg - 36'd1;
        rem_dec    = unit_remaining_reg - 64'd1;
        bias_shift = bias >> {address_byte_index_reg[2:0], 3'b000};
        bias_byte  = 8'h00;
        sum        = 9'd0;
        abi_inc    = {1'b0, address_byte_index_reg} + 9'd1;
        ent        = drar_pkg::enter_operand(entry_kind_reg, operand_index_reg + 2'd1,
                                             address_size_reg);

        case (phase_reg)
            drar_pkg::PH_LEN:
            begin
                in_unit = 1'b0;
                header_index_next = header_index_reg + 4'd1;
                if (header_index_reg < 4'd4)
                begin
                    len_acc = unit_remaining_reg
                        | ({56'd0, beat.data_byte} << {header_index_reg[1:0], 3'b000});
                    unit_remaining_next = len_acc;
                    if (header_index_reg == 4'd3)
                    begin
                        if (len_acc == drar_pkg::LEN_ESCAPE)
                        begin
                            long_format_next    = 1'b1;
                            unit_remaining_next = 64'd0;
                        end
                        else
                        begin
                            len_done = 1'b1;
                        end
                    end
                end
                else
                begin
                    len_acc = unit_remaining_reg
                        | ({56'd0, beat.data_byte}
                           << {header_index_reg[2:0] - 3'd4, 3'b000});
                    unit_remaining_next = len_acc;
                    if (header_index_reg == 4'd11)
                    begin
                        len_done = 1'b1;
                    end
                end
                if (len_done)
                begin
                    header_index_next = 4'd0;
                    if (len_acc == 64'd0)
                    begin
                        phase_next = drar_pkg::PH_PASS_SECTION;
                        result.parse_status = drar_pkg::ST_SECTION_PASS;
                    end
                    else
                    begin
                        phase_next = drar_pkg::PH_HDR;
                    end
                end
            end
            drar_pkg::PH_HDR:
            begin
                if (header_index_reg == 4'd2)
                begin
                    address_size_next = beat.data_byte;
                end
                else if (header_index_reg >= 4'd4)
                begin
                    offs_acc = offset_skip_reg
                        | ({28'd0, beat.data_byte} << {header_index_reg[1:0], 3'b000});
                end
                offset_skip_next  = offs_acc;
                header_index_next = header_index_reg + 4'd1;
                if (header_index_reg == 4'd7)
                begin
                    header_index_next = 4'd0;
                    offset_skip_next  = long_format_reg ? (offs_acc << 3) : (offs_acc << 2);
                    phase_next = (offs_acc != 36'd0) ? drar_pkg::PH_OFFS
                                                     : drar_pkg::PH_KIND;
                end
            end
            drar_pkg::PH_OFFS:
            begin
                offset_skip_next = offs_dec;
                if (offs_dec == 36'd0)
                begin
                    phase_next = drar_pkg::PH_KIND;
                end
            end
            drar_pkg::PH_KIND:
            begin
                if (beat.data_byte > drar_pkg::KIND_MAX)
                begin
                    phase_next = drar_pkg::PH_PASS_UNIT;
                    result.parse_status = drar_pkg::ST_UNIT_PASS;
                end
                else
                begin
                    entry_kind_next = beat.data_byte[2:0];
                    ent = drar_pkg::enter_operand(beat.data_byte[2:0], 2'd0,
                                                  address_size_reg);
                    phase_next         = ent.phase;
                    operand_index_next = ent.idx;
                    if (ent.phase == drar_pkg::PH_OPER)
                    begin
                        address_byte_index_next = 8'd0;
                        add_carry_next          = 1'b0;
                    end
                end
            end
            drar_pkg::PH_OPER:
            begin
                if (drar_pkg::operand_is_address(entry_kind_reg, operand_index_reg))
                begin
                    if (address_byte_index_reg < 8'd8)
                    begin
                        bias_byte = bias_shift[7:0];
                    end
                    sum = {1'b0, beat.data_byte} + {1'b0, bias_byte}
                        + {8'd0, add_carry_reg};
                    result.out_byte        = sum[7:0];
                    result.address_patched = (bias != 64'd0);
                    add_carry_next          = sum[8];
                    address_byte_index_next = abi_inc[7:0];
                    if (abi_inc >= {1'b0, address_size_reg})
                    begin
                        phase_next         = ent.phase;
                        operand_index_next = ent.idx;
                        if (ent.phase == drar_pkg::PH_OPER)
                        begin
                            address_byte_index_next = 8'd0;
                            add_carry_next          = 1'b0;
                        end
                    end
                end
                else if (!beat.data_byte[7])
                begin
                    phase_next         = ent.phase;
                    operand_index_next = ent.idx;
                    if (ent.phase == drar_pkg::PH_OPER)
                    begin
                        address_byte_index_next = 8'd0;
                        add_carry_next          = 1'b0;
                    end
                end
            end
            drar_pkg::PH_PASS_UNIT:
            begin
                result.parse_status = drar_pkg::ST_UNIT_PASS;
            end
            default:
            begin
                in_unit = 1'b0;
                result.parse_status = drar_pkg::ST_SECTION_PASS;
            end
        endcase

        if (in_unit)
        begin
            unit_remaining_next = rem_dec;
            if (rem_dec == 64'd0)
            begin
                clear = 1'b1;
            end
        end
        if (beat.last_byte)
        begin
            clear = 1'b1;
        end

        if (clear)
        begin
            phase_next              = drar_pkg::PH_LEN;
            unit_remaining_next     = 64'd0;
            header_index_next       = 4'd0;
            long_format_next        = 1'b0;
            address_size_next       = 8'd0;
            offset_skip_next        = 36'd0;
            entry_kind_next         = 3'd0;
            operand_index_next      = 2'd0;
            address_byte_index_next = 8'd0;
            add_carry_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg              <= drar_pkg::PH_LEN;
            unit_remaining_reg     <= 64'd0;
            header_index_reg       <= 4'd0;
            long_format_reg        <= 1'b0;
            address_size_reg       <= 8'd0;
            offset_skip_reg        <= 36'd0;
            entry_kind_reg         <= 3'd0;
            operand_index_reg      <= 2'd0;
            address_byte_index_reg <= 8'd0;
            add_carry_reg          <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg              <= phase_next;
            unit_remaining_reg     <= unit_remaining_next;
            header_index_reg       <= header_index_next;
            long_format_reg        <= long_format_next;
            address_size_reg       <= address_size_next;
            offset_skip_reg        <= offset_skip_next;
            entry_kind_reg         <= entry_kind_next;
            operand_index_reg      <= operand_index_next;
            address_byte_index_reg <= address_byte_index_next;
            add_carry_reg          <= add_carry_next;
        end
    end

    `DRAR_ASSERT_NEXT(a_last_clears_parse, fire && beat.last_byte, (phase_reg == drar_pkg::PH_LEN) && (unit_remaining_reg == 64'd0))
    `DRAR_ASSERT_IMPL(a_section_pass_no_length, phase_reg == drar_pkg::PH_PASS_SECTION, unit_remaining_reg == 64'd0)
    `DRAR_ASSERT_IMPL(a_operand_in_range, phase_reg == drar_pkg::PH_OPER, operand_index_reg < drar_pkg::operand_count(entry_kind_reg))

endmodule

>>> hdl/dwarf_rnglists_address_rebase.sv
// An accepted byte is held in the input register, then registered into the result register
// that drives the patch channel. Throughput: one byte per cycle unless patch_stall holds;
// the parser state and the 8-bit add with carry update once per beat between the two registers.
// Reset clears the bias to zero, empties both registers and puts the parser
// back to awaiting a unit length.
`include "dwarf_rnglists_address_rebase_macros.svh"

module dwarf_rnglists_address_rebase (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sect_valid,
    output logic                  sect_stall,
    input  drar_pkg::sect_beat_t  sect_beat,
    output logic                  patch_valid,
    input  logic                  patch_stall,
    output drar_pkg::patch_beat_t patch_beat,
    input  logic                  cfg_write,
    input  logic [63:0]           cfg_data
);

    logic                  in_valid_reg;
    drar_pkg::sect_beat_t  in_beat_reg;
    logic                  patch_valid_reg;
    drar_pkg::patch_beat_t patch_beat_reg;
    logic [63:0]           bias_reg;
    logic                  out_free;
    logic                  s1_fire;
    drar_pkg::patch_beat_t result;

    assign out_free   = !patch_valid_reg || !patch_stall;
    assign s1_fire    = in_valid_reg && out_free;
    assign sect_stall = in_valid_reg && !out_free;

    drar_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .beat   (in_beat_reg),
        .bias   (bias_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            patch_valid_reg <= 1'b0;
            bias_reg        <= 64'd0;
        end
        else
        begin
            if (!sect_stall)
            begin
                in_valid_reg <= sect_valid;
            end
            if (out_free)
            begin
                patch_valid_reg <= s1_fire;
            end
            if (cfg_write)
            begin
                bias_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sect_stall && sect_valid)
        begin
            in_beat_reg <= sect_beat;
        end
        if (s1_fire)
        begin
            patch_beat_reg <= result;
        end
    end

    assign patch_valid = patch_valid_reg;
    assign patch_beat  = patch_beat_reg;

    `DRAR_ASSERT_IMPL(a_zero_bias_no_patch, patch_valid_reg && (bias_reg == 64'd0), !patch_beat_reg.address_patched)
    `DRAR_ASSERT_IMPL(a_patch_only_normal, patch_valid_reg && patch_beat_reg.address_patched, patch_beat_reg.parse_status == drar_pkg::ST_NORMAL)
    `DRAR_ASSERT_NEXT(a_held_beat_kept, in_valid_reg && sect_stall, in_valid_reg)

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  sect_valid;
    logic                  sect_stall;
    drar_pkg::sect_beat_t  sect_beat;
    logic                  patch_valid;
    logic                  patch_stall;
    drar_pkg::patch_beat_t patch_beat;
    logic                  cfg_write;
    logic [63:0]           cfg_data;

    drar_pkg::sect_beat_t  pending_bytes[$];
    drar_pkg::patch_beat_t expected_patches[$];
    logic [7:0]            sect_bytes[$];
    logic [7:0]            unit_body[$];

    bit          sect_fired = 1'b0;
    int          idle_pct = 23;
    int          bytes_queued = 0;
    int          sections_sent = 0;
    int          settings_used = 0;
    int          beats_checked = 0;
    int          rebased_count = 0;
    int          unit_pass_count = 0;
    int          section_pass_count = 0;
    int          mismatches = 0;

    // Predictor state.
    logic [63:0]      bias_model;
    drar_pkg::phase_t parse_ph;
    logic [63:0]      unit_left;
    int               hdr_idx;
    bit               long_fmt;
    logic [7:0]       addr_bytes;
    logic [63:0]      offs_left;
    logic [2:0]       cur_kind;
    int               op_idx;
    int               addr_bidx;
    bit               carry_in;

    dwarf_rnglists_address_rebase uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sect_valid  (sect_valid),
        .sect_stall  (sect_stall),
        .sect_beat   (sect_beat),
        .patch_valid (patch_valid),
        .patch_stall (patch_stall),
        .patch_beat  (patch_beat),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int operand_total(input logic [2:0] kind);
        if (kind == drar_pkg::KIND_END_OF_LIST)
        begin
            return 0;
        end
        if (kind == drar_pkg::KIND_BASE_ADDRESSX || kind == drar_pkg::KIND_BASE_ADDRESS)
        begin
            return 1;
        end
        return 2;
    endfunction

    function automatic bit is_address_operand(input logic [2:0] kind, input int idx);
        return kind == drar_pkg::KIND_BASE_ADDRESS || kind == drar_pkg::KIND_START_END
            || (kind == drar_pkg::KIND_START_LENGTH && idx == 0);
    endfunction

    function automatic void parser_clear();
        parse_ph   = drar_pkg::PH_LEN;
        unit_left  = '0;
        hdr_idx    = 0;
        long_fmt   = 1'b0;
        addr_bytes = '0;
        offs_left  = '0;
        cur_kind   = '0;
        op_idx     = 0;
        addr_bidx  = 0;
        carry_in   = 1'b0;
    endfunction

    // Address operands of zero size are stepped over without taking a beat.
    function automatic void step_operand();
        bit placed;
        placed = 1'b0;
        while (!placed)
        begin
            if (op_idx >= operand_total(cur_kind))
            begin
                parse_ph = drar_pkg::PH_KIND;
                placed = 1'b1;
            end
            else if (is_address_operand(cur_kind, op_idx) && addr_bytes == 8'd0)
            begin
                op_idx++;
            end
            else
            begin
                parse_ph = drar_pkg::PH_OPER;
                addr_bidx = 0;
                carry_in = 1'b0;
                placed = 1'b1;
            end
        end
    endfunction

    function automatic drar_pkg::patch_beat_t rebase_byte(input drar_pkg::sect_beat_t s);
        drar_pkg::patch_beat_t r;
        logic [7:0]  b;
        logic [63:0] wide;
        logic [63:0] shifted;
        logic [8:0]  sum;
        bit          in_unit;
        bit          len_complete;
        b = s.data_byte;
        wide = {56'd0, b};
        r.out_byte = b;
        r.address_patched = 1'b0;
        r.parse_status = drar_pkg::ST_NORMAL;
        r.last_out = s.last_byte;
        in_unit = 1'b1;
        case (parse_ph)
            drar_pkg::PH_LEN:
            begin
                in_unit = 1'b0;
                if (hdr_idx < 4)
                begin
                    unit_left = unit_left | (wide << (8 * hdr_idx));
                    hdr_idx++;
                    len_complete = (hdr_idx == 4) && (unit_left != drar_pkg::LEN_ESCAPE);
                    if (hdr_idx == 4 && unit_left == drar_pkg::LEN_ESCAPE)
                    begin
                        long_fmt = 1'b1;
                        unit_left = '0;
                    end
                end
                else
                begin
                    unit_left = unit_left | (wide << (8 * ((hdr_idx - 4) & 7)));
                    hdr_idx++;
                    len_complete = (hdr_idx == 12);
                end
                if (len_complete)
                begin
                    hdr_idx = 0;
                    if (unit_left == 64'd0)
                    begin
                        parse_ph = drar_pkg::PH_PASS_SECTION;
                        r.parse_status = drar_pkg::ST_SECTION_PASS;
                    end
                    else
                    begin
                        parse_ph = drar_pkg::PH_HDR;
                    end
                end
            end
            drar_pkg::PH_HDR:
            begin
                if (hdr_idx == 2)
                begin
                    addr_bytes = b;
                end
                else if (hdr_idx >= 4)
                begin
                    offs_left = offs_left | (wide << (8 * (hdr_idx - 4)));
                end
                hdr_idx++;
                if (hdr_idx >= 8)
                begin
                    hdr_idx = 0;
                    offs_left = long_fmt ? (offs_left << 3) : (offs_left << 2);
                    parse_ph = (offs_left != 64'd0) ? drar_pkg::PH_OFFS : drar_pkg::PH_KIND;
                end
            end
            drar_pkg::PH_OFFS:
            begin
                offs_left = offs_left - 64'd1;
                if (offs_left == 64'd0)
                begin
                    parse_ph = drar_pkg::PH_KIND;
                end
            end
            drar_pkg::PH_KIND:
            begin
                if (b > drar_pkg::KIND_MAX)
                begin
                    parse_ph = drar_pkg::PH_PASS_UNIT;
                    r.parse_status = drar_pkg::ST_UNIT_PASS;
                end
                else
                begin
                    cur_kind = b[2:0];
                    op_idx = 0;
                    step_operand();
                end
            end
            drar_pkg::PH_OPER:
            begin
                if (is_address_operand(cur_kind, op_idx))
                begin
                    shifted = (addr_bidx < 8) ? (bias_model >> (8 * addr_bidx)) : 64'd0;
                    sum = {1'b0, b} + {1'b0, shifted[7:0]} + {8'd0, carry_in};
                    r.out_byte = sum[7:0];
                    carry_in = sum[8];
                    r.address_patched = (bias_model != 64'd0);
                    addr_bidx++;
                    if (addr_bidx >= addr_bytes)
                    begin
                        op_idx++;
                        step_operand();
                    end
                end
                else if (!b[7])
                begin
                    op_idx++;
                    step_operand();
                end
            end
            drar_pkg::PH_PASS_UNIT:
            begin
                r.parse_status = drar_pkg::ST_UNIT_PASS;
            end
            default:
            begin
                in_unit = 1'b0;
                r.parse_status = drar_pkg::ST_SECTION_PASS;
            end
        endcase
        if (in_unit)
        begin
            unit_left = unit_left - 64'd1;
            if (unit_left == 64'd0)
            begin
                parser_clear();
            end
        end
        if (s.last_byte)
        begin
            parser_clear();
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        return v;
    endfunction

    // Address bytes lean towards 0xff so that carries run across the field.
    function automatic logic [7:0] address_byte();
        return ($urandom_range(2) == 0) ? 8'hff : rand_byte();
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic is_last);
        drar_pkg::sect_beat_t beat;
        beat.data_byte = b;
        beat.last_byte = is_last;
        pending_bytes.push_back(beat);
        bytes_queued++;
    endtask

    task automatic add_unit();
        bit          long_f;
        int          asz;
        int          n_offs;
        int          n_ent;
        int          kind;
        int          n;
        logic [7:0]  b;
        logic [63:0] len;
        unit_body.delete();
        long_f = ($urandom_range(7) == 0);
        case ($urandom_range(5))
            0: asz = 0;
            1: asz = 1;
            2: asz = 4;
            3, 4: asz = 8;
            default: asz = $urandom_range(2, 12);
        endcase
        n_offs = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        unit_body.push_back(($urandom_range(9) == 0) ? rand_byte() : 8'h05);
        unit_body.push_back(8'h00);
        unit_body.push_back(asz[7:0]);
        unit_body.push_back(($urandom_range(9) == 0) ? rand_byte() : 8'h00);
        unit_body.push_back(n_offs[7:0]);
        repeat (3) unit_body.push_back(8'h00);
        repeat (n_offs * (long_f ? 8 : 4)) unit_body.push_back(rand_byte());
        n_ent = $urandom_range(1, 6);
        for (int e = 0; e < n_ent; e++)
        begin
            if ($urandom_range(19) == 0)
            begin
                b = 8'($urandom_range(8, 255));
                unit_body.push_back(b);
                repeat ($urandom_range(0, 4)) unit_body.push_back(rand_byte());
                break;
            end
            kind = $urandom_range(7);
            unit_body.push_back(kind[7:0]);
            for (int op = 0; op < operand_total(kind[2:0]); op++)
            begin
                if (is_address_operand(kind[2:0], op))
                begin
                    repeat (asz) unit_body.push_back(address_byte());
                end
                else
                begin
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++)
                    begin
                        b = rand_byte();
                        b[7] = (k != n - 1);
                        unit_body.push_back(b);
                    end
                end
            end
        end
        len = 64'(unit_body.size());
        if ($urandom_range(9) == 0)
        begin
            len = 64'($urandom_range(1, unit_body.size() + 4));
        end
        if (long_f)
        begin
            repeat (4) sect_bytes.push_back(8'hff);
            for (int i = 0; i < 8; i++)
            begin
                sect_bytes.push_back(len[8 * i +: 8]);
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                sect_bytes.push_back(len[8 * i +: 8]);
            end
        end
        foreach (unit_body[i])
        begin
            sect_bytes.push_back(unit_body[i]);
        end
    endtask

    task automatic add_section();
        int cut;
        sect_bytes.delete();
        case ($urandom_range(19))
            0:
            begin
                repeat ($urandom_range(1, 24)) sect_bytes.push_back(rand_byte());
            end
            1:
            begin
                if ($urandom_range(1) == 1)
                begin
                    add_unit();
                end
                if ($urandom_range(1) == 1)
                begin
                    repeat (4) sect_bytes.push_back(8'hff);
                    repeat (8) sect_bytes.push_back(8'h00);
                end
                else
                begin
                    repeat (4) sect_bytes.push_back(8'h00);
                end
                repeat ($urandom_range(0, 6)) sect_bytes.push_back(rand_byte());
            end
            default:
            begin
                repeat ($urandom_range(1, 3)) add_unit();
            end
        endcase
        if ($urandom_range(9) == 0 && sect_bytes.size() > 1)
        begin
            cut = $urandom_range(1, sect_bytes.size() - 1);
            while (sect_bytes.size() > cut)
            begin
                void'(sect_bytes.pop_back());
            end
        end
        foreach (sect_bytes[i])
        begin
            queue_byte(sect_bytes[i], i == sect_bytes.size() - 1);
        end
        sections_sent++;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || sect_valid || expected_patches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bias(input logic [63:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        bias_model = v;
        settings_used++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sect_valid || sect_fired)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    sect_beat  <= pending_bytes.pop_front();
                    sect_valid <= 1'b1;
                end
                else
                begin
                    sect_valid <= 1'b0;
                end
            end
            patch_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge clk)
    begin
        drar_pkg::patch_beat_t want;
        drar_pkg::patch_beat_t prediction;
        if (rst_n)
        begin
            sect_fired = sect_valid && !sect_stall;
            if (sect_fired)
            begin
                prediction = rebase_byte(sect_beat);
                expected_patches.push_back(prediction);
                if (prediction.address_patched)
                begin
                    rebased_count++;
                end
                if (prediction.parse_status == drar_pkg::ST_UNIT_PASS)
                begin
                    unit_pass_count++;
                end
                if (prediction.parse_status == drar_pkg::ST_SECTION_PASS)
                begin
                    section_pass_count++;
                end
            end
            if (patch_valid && !patch_stall)
            begin
                if (expected_patches.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Unexpected beat with byte %02h while nothing was outstanding",
                                 patch_beat.out_byte);
                    end
                end
                else
                begin
                    want = expected_patches.pop_front();
                    if (patch_beat.out_byte !== want.out_byte
                        || patch_beat.address_patched !== want.address_patched
                        || patch_beat.parse_status !== want.parse_status
                        || patch_beat.last_out !== want.last_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch on beat %0d: expected byte %02h patched %0b",
                                     beats_checked, want.out_byte, want.address_patched,
                                     " status %0d last %0b, got byte %02h patched %0b",
                                     want.parse_status, want.last_out,
                                     patch_beat.out_byte, patch_beat.address_patched,
                                     " status %0d last %0b",
                                     patch_beat.parse_status, patch_beat.last_out);
                        end
                    end
                end
                beats_checked++;
            end
        end
    end

    initial
    begin
        logic [7:0]  directed[$];
        logic [63:0] bias_list[$];
        int          phase_start;
        rst_n       = 1'b0;
        sect_valid  = 1'b0;
        sect_beat   = '0;
        patch_stall = 1'b0;
        cfg_write   = 1'b0;
        cfg_data    = '0;
        bias_model  = '0;
        parser_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // One unit with every address kind, an unknown kind closing it, then a zero length.
        write_bias('1);
        directed = '{8'h16, 8'h00, 8'h00, 8'h00,
                     8'h05, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h06, 8'hff, 8'hff, 8'h00, 8'h80,
                     8'h07, 8'hff, 8'hff, 8'h81, 8'h01,
                     8'h05, 8'h01, 8'h00,
                     8'h09,
                     8'h00, 8'h00, 8'h00, 8'h00};
        foreach (directed[i])
        begin
            queue_byte(directed[i], i == directed.size() - 1);
        end
        sections_sent++;
        wait_drained();

        bias_list.push_back(64'd0);
        bias_list.push_back('1);
        bias_list.push_back(64'd1);
        bias_list.push_back(64'h8000_0000_0000_0000);
        bias_list.push_back({$urandom, $urandom});
        bias_list.push_back({$urandom, $urandom});
        foreach (bias_list[p])
        begin
            write_bias(bias_list[p]);
            idle_pct = (p == 3) ? 0 : 23;
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 170)
            begin
                add_section();
            end
            wait_drained();
        end

        $display("Checked %0d beats from %0d sections under %0d bias settings;",
                 beats_checked, sections_sent, settings_used);
        $display("%0d bytes rebased, %0d in skipped units, %0d in skipped section tails.",
                 rebased_count, unit_pass_count, section_pass_count);
        if (mismatches == 0 && expected_patches.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
